@@ design/osr_pkg.sv @@
// Shared types, codes and defaults for the order-statistic remove block.
`default_nettype none

package osr_pkg;

  localparam int unsigned CapacityDef   = 1024;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned RankWidth     = 11;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_CLEARED = 2'd3;

  typedef struct packed {
    logic [1:0]           command;
    logic [31:0]          value;
    logic [RankWidth-1:0] rank;
  } in_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic [1:0]  status;
  } out_t;

endpackage

`default_nettype wire

@@ design/order_statistic_remove_top.sv @@
// Order-statistic list in a binary count tree: append, remove by rank, clear.
// With L = clog2(CAPACITY), a remove walks L levels down, then L ancestors
// back up, one count RAM read per level, before its result is registered;
// an append walks only the L ancestors up, and any other beat goes straight
// to the output stage. No new beat is taken until the result is registered.
// Reset empties the list at once; a clear empties it at its accepting edge.
`default_nettype none

module order_statistic_remove_top #(
  parameter int unsigned CAPACITY    = osr_pkg::CapacityDef,
  parameter int unsigned VALUE_WIDTH = osr_pkg::ValueWidthDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire osr_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output osr_pkg::out_t      out_data_o
);

  localparam int unsigned L         = $clog2(CAPACITY);
  localparam int unsigned K         = 1 << L;
  localparam int unsigned NW        = L + 1;
  localparam int unsigned TreeDepth = 2 * K;
  localparam int unsigned CW        = $clog2(CAPACITY + 1);
  localparam int unsigned RKW       = (CW > osr_pkg::RankWidth) ? CW : osr_pkg::RankWidth;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DOWN = 2'd1;
  localparam logic [1:0] S_UP   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [NW-1:0] node_q, node_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [L-1:0]  mask_q, mask_d;
  logic [L-1:0]  slot_q, slot_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] live_q, live_d;
  logic          is_remove_q, is_remove_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  osr_pkg::out_t out_data_q, out_data_d;

  logic                   c_we, c_re;
  logic [NW-1:0]          c_waddr, c_raddr;
  logic [CW-1:0]          c_wdata, c_rdata;
  logic                   v_we, v_re;
  logic [L-1:0]           v_raddr;
  logic [VALUE_WIDTH-1:0] v_rdata;

  logic          alu_sub, alu_carry;
  logic [CW-1:0] alu_a, alu_b, alu_sum;

  logic [RKW-1:0] rank_ext, live_ext;
  logic [NW-1:0]  nxt;
  logic           fresh, out_free;

  osr_ram #(
    .Width(CW),
    .Depth(TreeDepth)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .re_i   (c_re),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  osr_ram #(
    .Width(VALUE_WIDTH),
    .Depth(CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(fill_q[L-1:0]),
    .wdata_i(VALUE_WIDTH'(in_data_i.value)),
    .re_i   (v_re),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  osr_alu #(
    .Width(CW)
  ) u_alu (
    .sub_i  (alu_sub),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  assign rank_ext = RKW'(in_data_i.rank);
  assign live_ext = RKW'(live_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // A tree node counts only once its leftmost leaf has been filled since the
  // last clear; on an append the ancestors whose leftmost leaf is the new
  // slot start over at one instead of using stale RAM contents.
  assign fresh = !is_remove_q && ((slot_q & mask_q) == '0);

  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    rem_d        = rem_q;
    mask_d       = mask_q;
    slot_d       = slot_q;
    fill_d       = fill_q;
    live_d       = live_q;
    is_remove_d  = is_remove_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    c_we    = 1'b0;
    c_waddr = node_q;
    c_wdata = '0;
    c_re    = 1'b0;
    c_raddr = node_q;
    v_we    = 1'b0;
    v_re    = 1'b0;
    v_raddr = '0;

    alu_sub = 1'b1;
    alu_a   = rem_q;
    alu_b   = c_rdata;

    nxt = alu_carry ? {node_q[NW-2:0], 1'b1} : {node_q[NW-2:0], 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          is_remove_d  = 1'b0;
          res_status_d = osr_pkg::STATUS_OK;
          state_d      = S_EMIT;
          case (in_data_i.command)
            osr_pkg::CMD_APPEND: begin
              if (fill_q == CW'(CAPACITY)) begin
                res_status_d = osr_pkg::STATUS_FULL;
              end else begin
                v_we    = 1'b1;
                c_we    = 1'b1;
                c_waddr = NW'(K) | NW'(fill_q[L-1:0]);
                c_wdata = CW'(1);
                c_re    = 1'b1;
                c_raddr = c_waddr >> 1;
                node_d  = c_raddr;
                slot_d  = fill_q[L-1:0];
                mask_d  = L'(1);
                fill_d  = fill_q + CW'(1);
                live_d  = live_q + CW'(1);
                state_d = S_UP;
              end
            end
            osr_pkg::CMD_REMOVE: begin
              if (rank_ext == '0 || rank_ext > live_ext) begin
                res_status_d = osr_pkg::STATUS_RANGE;
              end else begin
                is_remove_d = 1'b1;
                rem_d       = CW'(rank_ext - RKW'(1));
                node_d      = NW'(1);
                c_re        = 1'b1;
                c_raddr     = NW'(2);
                live_d      = live_q - CW'(1);
                state_d     = S_DOWN;
              end
            end
            osr_pkg::CMD_CLEAR: begin
              fill_d       = '0;
              live_d       = '0;
              res_status_d = osr_pkg::STATUS_CLEARED;
            end
            default: begin
              res_status_d = osr_pkg::STATUS_OK;
            end
          endcase
        end
      end

      S_DOWN: begin
        // The read data is the left child's count; steer on rem - count.
        if (alu_carry) begin
          rem_d = alu_sum;
        end
        if (nxt[L]) begin
          c_we    = 1'b1;
          c_waddr = nxt;
          c_wdata = '0;
          c_re    = 1'b1;
          c_raddr = node_q;
          v_re    = 1'b1;
          v_raddr = nxt[L-1:0];
          mask_d  = L'(1);
          state_d = S_UP;
        end else begin
          node_d  = nxt;
          c_re    = 1'b1;
          c_raddr = NW'({nxt, 1'b0});
        end
      end

      S_UP: begin
        alu_sub = is_remove_q;
        alu_a   = c_rdata;
        alu_b   = CW'(1);
        c_we    = 1'b1;
        c_waddr = node_q;
        c_wdata = fresh ? CW'(1) : alu_sum;
        if (node_q == NW'(1)) begin
          state_d = S_EMIT;
        end else begin
          c_re    = 1'b1;
          c_raddr = node_q >> 1;
          node_d  = node_q >> 1;
          mask_d  = (mask_q << 1) | L'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = res_status_q;
          out_data_d.removed_value = is_remove_q ? 32'(v_rdata) : 32'd0;
          state_d                  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    rem_q        <= rem_d;
    mask_q       <= mask_d;
    slot_q       <= slot_d;
    is_remove_q  <= is_remove_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ design/osr_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module osr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/osr_alu.sv @@
// Shared add/subtract unit used for rank steering and count updates.
`default_nettype none

module osr_alu #(
  parameter int unsigned Width = 11
) (
  input  wire              sub_i,
  input  wire [Width-1:0]  a_i,
  input  wire [Width-1:0]  b_i,
  output logic [Width-1:0] sum_o,
  output logic             carry_o
);

  logic [Width:0] full;

  // On a subtract, carry out set means a is not below b.
  always_comb begin
    full = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{Width{1'b0}}, sub_i};
  end

  assign sum_o   = full[Width-1:0];
  assign carry_o = full[Width];

endmodule

`default_nettype wire
